// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- sv/fcpq_pkg.sv -----
`timescale 1ns / 1ps

package fcpq_pkg;

  localparam int NUM_CLASSES     = 4;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int TIME_W   = 11;
  localparam int WAIT_W   = 12;
  localparam int DEPTH_W  = 7;
  localparam int CNT16_W  = 16;
  localparam int PEAK_W   = 9;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 96;

  typedef enum logic [1:0] {
    CMD_ARRIVE = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic issue;   // request taken: latch it, access the time store
    logic finish;  // update state and load the result register
  } ctrl_cmd_t;

endpackage

// ----- sv/four_class_priority_queue_stats_top.sv -----
`timescale 1ns / 1ps

// Four-class strict-priority queue with service statistics. Each request is
// an arrival (stores hour*60+minute in its class's ring), a serve (pops the
// oldest entry of the lowest-numbered non-empty class and returns the signed
// wait) or a report (returns one class's served count); every request gives
// exactly one result carrying queue depths, peak occupancy, total served and
// longest wait. The accept edge of a request does the single access to the
// time store (write for an arrival, registered read for a serve); the
// finishing edge, once the output register frees, updates the counters and
// loads the result register. The input is taken again the cycle after that,
// so no new request is taken before the last one is finished; a result not
// taken holds the finishing step until the output register frees. The time
// store has no reset: its read data are only used behind the fill counts.
module four_class_priority_queue_stats_top #(
  parameter int QUEUE_DEPTH = fcpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [1:0]                    s_axis_tuser,  // [1:0] command
  // [1:0] priority_class, [6:2] hour, [12:7] minute, [15:13] zero
  input  logic [fcpq_pkg::S_DATA_W-1:0] s_axis_tdata,
  // result side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [1:0]                    m_axis_tuser,  // [1:0] status
  // [1:0] served_class, [13:2] wait_minutes, [20:14] waiting_red,
  // [27:21] waiting_yellow, [34:28] waiting_green, [41:35] waiting_white,
  // [57:42] total_served, [66:58] peak_occupancy, [78:67] max_wait,
  // [94:79] class_served_count, [95] zero
  output logic [fcpq_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import fcpq_pkg::*;

  ctrl_cmd_t cmd;

  fcpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  fcpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .s_user_i (s_axis_tuser),
    .s_data_i (s_axis_tdata),
    .m_user_o (m_axis_tuser),
    .m_data_o (m_axis_tdata)
  );

endmodule

// ----- sv/fcpq_ctrl.sv -----
`timescale 1ns / 1ps

module fcpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output fcpq_pkg::ctrl_cmd_t cmd_o
);
  import fcpq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   can_load;

  assign s_ready_o    = (state_q == S_IDLE);
  assign can_load     = !m_valid_q || m_ready_i;
  assign cmd_o.issue  = s_valid_i && (state_q == S_IDLE);
  assign cmd_o.finish = (state_q == S_FIN) && can_load;
  assign m_valid_o    = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_valid_i) state_q <= S_FIN;
          if (m_ready_i) m_valid_q <= 1'b0;
        end
        S_FIN: begin
          if (can_load) begin
            state_q   <= S_IDLE;
            m_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/fcpq_datapath.sv -----
`timescale 1ns / 1ps

module fcpq_datapath #(
  parameter int QUEUE_DEPTH = fcpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fcpq_pkg::ctrl_cmd_t             cmd_i,
  input  logic [1:0]                      s_user_i,
  input  logic [fcpq_pkg::S_DATA_W-1:0]   s_data_i,
  output logic [1:0]                      m_user_o,
  output logic [fcpq_pkg::M_DATA_W-1:0]   m_data_o
);
  import fcpq_pkg::*;

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int OW = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_CLASSES * QUEUE_DEPTH);
  localparam int MEM_N = NUM_CLASSES * QUEUE_DEPTH;

  // time store, one ring of QUEUE_DEPTH entries per class
  logic [TIME_W-1:0] mem [MEM_N];

  logic [HW-1:0]      head_q   [NUM_CLASSES];
  logic [CW-1:0]      cnt_q    [NUM_CLASSES];
  logic [CW-1:0]      cnt_d    [NUM_CLASSES];
  logic [CNT16_W-1:0] served_q [NUM_CLASSES];
  logic [OW-1:0]      occ_q, occ_d, peak_q, peak_d;
  logic [CNT16_W-1:0] total_q, total_d;
  logic signed [WAIT_W-1:0] longest_q, longest_d;
  logic               any_q;

  // latched request
  cmd_e              op_q;
  logic [1:0]        cls_q, srv_q;
  logic [TIME_W-1:0] now_q, rd_q;
  logic              found_q, full_q;

  // request decode at the accept edge
  cmd_e              in_op;
  logic [1:0]        in_cls, srv_sel, cls_sel;
  logic [TIME_W-1:0] hour_x, in_now;
  logic              found, full, we;
  logic [HW:0]       slot_sum, slot_w;
  logic [HW-1:0]     idx;
  logic [AW-1:0]     addr;

  assign in_op  = cmd_e'(s_user_i);
  assign in_cls = s_data_i[1:0];
  assign hour_x = TIME_W'(s_data_i[6:2]);
  // hour*60 = hour*64 - hour*4
  assign in_now = (hour_x << 6) - (hour_x << 2) + TIME_W'(s_data_i[12:7]);

  always_comb begin
    found   = 1'b0;
    srv_sel = 2'd0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cnt_q[c] != '0) begin
        found   = 1'b1;
        srv_sel = 2'(c);
      end
    end
  end

  assign full     = (cnt_q[in_cls] == CW'(QUEUE_DEPTH));
  assign slot_sum = (HW+1)'(head_q[in_cls]) + (HW+1)'(cnt_q[in_cls]);
  assign slot_w   = (slot_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                    slot_sum - (HW+1)'(QUEUE_DEPTH) : slot_sum;
  assign cls_sel  = (in_op == CMD_ARRIVE) ? in_cls : srv_sel;
  assign idx      = (in_op == CMD_ARRIVE) ? slot_w[HW-1:0] : head_q[srv_sel];
  assign addr     = AW'(cls_sel) * AW'(QUEUE_DEPTH) + AW'(idx);
  assign we       = cmd_i.issue && (in_op == CMD_ARRIVE) && !full;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      if (we) mem[addr] <= in_now;
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      op_q    <= in_op;
      cls_q   <= in_cls;
      now_q   <= in_now;
      srv_q   <= srv_sel;
      found_q <= found;
      full_q  <= full;
    end
  end

  // finishing step
  status_e                  st;
  logic [1:0]               srv_out;
  logic signed [WAIT_W-1:0] wait_v, wait_out;
  logic [CNT16_W-1:0]       cls_cnt;
  logic [HW:0]              head_inc;
  logic                     do_srv;

  assign wait_v   = $signed(WAIT_W'(now_q)) - $signed(WAIT_W'(rd_q));
  assign head_inc = (HW+1)'(head_q[srv_q]) + (HW+1)'(1);
  assign do_srv   = (op_q == CMD_SERVE) && found_q;

  always_comb begin
    st        = ST_OK;
    srv_out   = 2'd0;
    wait_out  = '0;
    cls_cnt   = '0;
    occ_d     = occ_q;
    peak_d    = peak_q;
    total_d   = total_q;
    longest_d = longest_q;
    for (int c = 0; c < NUM_CLASSES; c++) cnt_d[c] = cnt_q[c];
    unique case (op_q)
      CMD_ARRIVE: begin
        if (full_q) begin
          st = ST_FULL;
        end else begin
          cnt_d[cls_q] = cnt_q[cls_q] + CW'(1);
          occ_d        = occ_q + OW'(1);
          if (occ_d > peak_q) peak_d = occ_d;
        end
      end
      CMD_SERVE: begin
        if (!found_q) begin
          st = ST_EMPTY;
        end else begin
          srv_out      = srv_q;
          wait_out     = wait_v;
          cnt_d[srv_q] = cnt_q[srv_q] - CW'(1);
          occ_d        = occ_q - OW'(1);
          if (!any_q || (wait_v > longest_q)) longest_d = wait_v;
          if (total_q != '1) total_d = total_q + CNT16_W'(1);
        end
      end
      CMD_REPORT: cls_cnt = served_q[cls_q];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]   <= '0;
        cnt_q[c]    <= '0;
        served_q[c] <= '0;
      end
      occ_q     <= '0;
      peak_q    <= '0;
      total_q   <= '0;
      longest_q <= '0;
      any_q     <= 1'b0;
    end else if (cmd_i.finish) begin
      for (int c = 0; c < NUM_CLASSES; c++) cnt_q[c] <= cnt_d[c];
      occ_q     <= occ_d;
      peak_q    <= peak_d;
      total_q   <= total_d;
      longest_q <= longest_d;
      if (do_srv) begin
        any_q <= 1'b1;
        head_q[srv_q] <= (head_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[HW-1:0];
        if (served_q[srv_q] != '1) served_q[srv_q] <= served_q[srv_q] + CNT16_W'(1);
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      m_user_o <= st;
      m_data_o <= {1'b0,
                   cls_cnt,
                   longest_d,
                   PEAK_W'(peak_d),
                   total_d,
                   DEPTH_W'(cnt_d[3]),
                   DEPTH_W'(cnt_d[2]),
                   DEPTH_W'(cnt_d[1]),
                   DEPTH_W'(cnt_d[0]),
                   wait_out,
                   srv_out};
    end
  end

endmodule

// ----- sv/fcpq_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic [95:0] m_axis_tdata
);
  import fcpq_pkg::*;

  logic        s_take;
  logic        m_empty;
  logic [13:0] m_srv_wait;
  logic [15:0] m_total;
  logic [11:0] m_max_wait;

  assign s_take     = s_axis_tvalid && s_axis_tready;
  assign m_empty    = m_axis_tvalid && (m_axis_tuser == ST_EMPTY);
  assign m_srv_wait = m_axis_tdata[13:0];
  assign m_total    = m_axis_tdata[57:42];
  assign m_max_wait = m_axis_tdata[78:67];

  // one request in flight: no accept directly after an accept
  `ASSERT_CLK(a_one_in_flight, clk_i, rst_ni, s_take |=> !s_axis_tready)

  // a held result stays offered
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)

  // empty serve carries no class and no wait
  `ASSERT_CLK(a_empty_clean, clk_i, rst_ni, m_empty |-> (m_srv_wait == 14'd0))

  // longest wait stays zero until something has been served
  `ASSERT_CLK(a_max_wait_zero, clk_i, rst_ni, (m_axis_tvalid && m_total == 16'd0) |-> (m_max_wait == 12'd0))

  `ASSERT_NEVER(a_status_code, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser > ST_FULL))

endmodule

bind four_class_priority_queue_stats_top fcpq_checker u_fcpq_checker (.*);
